// ===== rtl/bblur_pkg.sv =====
// Shared types, constants and divide helpers for the 3x3 box-blur unit.
package bblur_pkg;

  localparam int CH_W        = 8;
  localparam int PIX_W       = 3 * CH_W;
  localparam int DIM_W       = 11;
  localparam int POS_W       = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int SUM_W       = 12;
  localparam int RECIP_W     = 15;
  localparam int RECIP_SHIFT = 16;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [DIM_W-1:0] DIM_MIN   = DIM_W'(2);
  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(2);

  localparam logic [1:0] DIV4 = 2'd0;
  localparam logic [1:0] DIV6 = 2'd1;
  localparam logic [1:0] DIV9 = 2'd2;

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } pix_item_t;

  typedef struct packed {
    logic [CH_W-1:0]  red_out;
    logic [CH_W-1:0]  green_out;
    logic [CH_W-1:0]  blue_out;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic             last_of_burst;
    logic             last_of_frame;
  } res_item_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] x;
    x = v;
    if (x < DIM_MIN) begin
      x = DIM_MIN;
    end else if (x > hi) begin
      x = hi;
    end
    return x;
  endfunction

  function automatic logic [1:0] div_code(input logic three_rows, input logic three_cols);
    logic [1:0] code;
    if (three_rows && three_cols) begin
      code = DIV9;
    end else if (three_rows || three_cols) begin
      code = DIV6;
    end else begin
      code = DIV4;
    end
    return code;
  endfunction

  // Rounded quotient is ((sum + n/2) * recip) >> RECIP_SHIFT, exact for sums below 2^13.
  function automatic logic [RECIP_W-1:0] div_recip(input logic [1:0] code);
    logic [RECIP_W-1:0] m;
    unique case (code)
      DIV4: m = RECIP_W'(16384);
      DIV6: m = RECIP_W'(10923);
      DIV9: m = RECIP_W'(7282);
      default: m = RECIP_W'(16384);
    endcase
    return m;
  endfunction

  function automatic logic [2:0] div_half(input logic [1:0] code);
    logic [2:0] h;
    unique case (code)
      DIV4: h = 3'd2;
      DIV6: h = 3'd3;
      DIV9: h = 3'd4;
      default: h = 3'd2;
    endcase
    return h;
  endfunction

endpackage

// ===== rtl/box_blur_3x3_edge_aware_unit.sv =====
// Streaming 3x3 edge-aware box blur with a two-line pixel memory and a result burst stage.
// Throughput: one item and one result per cycle while res_ready holds; in the last row each item
// carries two results, so items there are held back, while the extra results of a last-column
// item or of the last pixel are absorbed by the first-column or first-row items that follow and
// carry none.
// Synchronous reset empties the pipeline, zeroes the position and sets both dimensions to 2.
module box_blur_3x3_edge_aware_unit
  import bblur_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pix_valid,
  output logic                 pix_ready,
  input  pix_item_t            pix,
  output logic                 res_valid,
  input  logic                 res_ready,
  output res_item_t            res,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int RW      = $clog2(MAX_HEIGHT);
  localparam int CMPW    = (CW > DIM_W) ? CW : DIM_W;
  localparam int CMPH    = (RW > DIM_W) ? RW : DIM_W;
  localparam int DIM_TOP = (2 ** DIM_W) - 1;
  localparam int W_LIMIT = (MAX_WIDTH > DIM_TOP) ? DIM_TOP : MAX_WIDTH;
  localparam int H_LIMIT = (MAX_HEIGHT > DIM_TOP) ? DIM_TOP : MAX_HEIGHT;
  localparam logic [DIM_W-1:0] W_MAX = DIM_W'(W_LIMIT);
  localparam logic [DIM_W-1:0] H_MAX = DIM_W'(H_LIMIT);
  localparam logic [1:0] SLOT_LAST = 2'd3;
  localparam int PROD_W = SUM_W + RECIP_W;

  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic [CW-1:0]    in_col;
  logic [RW-1:0]    in_row;
  logic             last_col;
  logic             last_row;
  logic             pix_fire;
  logic             cfg_hit;

  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] mem_rd;

  logic              s1_valid;
  logic              s1_go;
  logic              s1_emit;
  logic              s1_r2;
  logic              s1_c2;
  logic              s1_last_col;
  logic              s1_last_row;
  logic [PIX_W-1:0]  s1_pix;
  logic [CW-1:0]     s1_addr;
  logic [POS_W-1:0]  s1_row;
  logic [POS_W-1:0]  s1_col;

  logic [2:0][PIX_W-1:0]        win0;
  logic [2:0][PIX_W-1:0]        win1;
  logic [2:0][PIX_W-1:0]        col_new;
  logic [2:0][2:0][PIX_W-1:0]   cols;
  logic [2:0][2:0][CH_W:0]      col_sb;
  logic [2:0][2:0][CH_W+1:0]    col_sa;

  logic                         s2_valid;
  logic                         s2_ready;
  logic                         s2_go;
  logic [2:0][2:0][CH_W:0]      s2_sb;
  logic [2:0][2:0][CH_W+1:0]    s2_sa;
  logic                         s2_r2;
  logic                         s2_c2;
  logic                         s2_last_col;
  logic                         s2_last_row;
  logic [POS_W-1:0]             s2_row;
  logic [POS_W-1:0]             s2_col;
  logic [3:0][1:0]              s2_code;
  logic [3:0][2:0][SUM_W-1:0]   s2_tot;

  logic                         s3_valid;
  logic                         s3_ready;
  logic                         s3_emit;
  logic                         s3_more;
  logic [1:0]                   s3_next;
  logic [1:0]                   s3_sel;
  logic [3:0]                   s3_mask;
  logic [3:0][1:0]              s3_code;
  logic [3:0][2:0][SUM_W-1:0]   s3_tot;
  logic [POS_W-1:0]             s3_row_up;
  logic [POS_W-1:0]             s3_row;
  logic [POS_W-1:0]             s3_col_left;
  logic [POS_W-1:0]             s3_col;

  logic                         out_load;
  logic [2:0][PROD_W-1:0]       prod;
  res_item_t                    res_next;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index == REG_FRAME_WIDTH ||
                                   cfg_index == REG_FRAME_HEIGHT);
  assign pix_fire  = pix_valid && pix_ready;
  assign last_col  = (CMPW'(in_col) == CMPW'(frame_width) - CMPW'(1));
  assign last_row  = (CMPH'(in_row) == CMPH'(frame_height) - CMPH'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_RESET;
      frame_height <= DIM_RESET;
      in_col       <= '0;
      in_row       <= '0;
    end else if (cfg_hit) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        frame_width <= clamp_dim(cfg_data, W_MAX);
      end else begin
        frame_height <= clamp_dim(cfg_data, H_MAX);
      end
      in_col <= '0;
      in_row <= '0;
    end else if (pix_fire) begin
      if (last_col) begin
        in_col <= '0;
        in_row <= last_row ? '0 : in_row + RW'(1);
      end else begin
        in_col <= in_col + CW'(1);
      end
    end
  end

  // Each entry holds the pixel two rows up in its upper half and one row up in its lower half.
  always_ff @(posedge clk) begin
    if (pix_fire) begin
      mem_rd <= line_mem[in_col];
    end
    if (s1_go) begin
      line_mem[s1_addr] <= {mem_rd[PIX_W-1:0], s1_pix};
    end
  end

  assign pix_ready = !s1_valid || s1_go;
  assign s1_go     = s1_valid && (!s1_emit || s2_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_ready) begin
      s1_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_fire) begin
      s1_pix      <= pix;
      s1_addr     <= in_col;
      s1_emit     <= (in_row != '0) && (in_col != '0);
      s1_r2       <= in_row > RW'(1);
      s1_c2       <= in_col > CW'(1);
      s1_last_col <= last_col;
      s1_last_row <= last_row;
      s1_row      <= POS_W'(in_row);
      s1_col      <= POS_W'(in_col);
    end
  end

  assign col_new = {s1_pix, mem_rd[PIX_W-1:0], mem_rd[2*PIX_W-1:PIX_W]};
  assign cols    = {col_new, win1, win0};

  always_ff @(posedge clk) begin
    if (s1_go) begin
      win0 <= win1;
      win1 <= col_new;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int ch = 0; ch < 3; ch++) begin
        col_sb[k][ch] = {1'b0, cols[k][1][ch*CH_W +: CH_W]} +
                        {1'b0, cols[k][2][ch*CH_W +: CH_W]};
        col_sa[k][ch] = {1'b0, col_sb[k][ch]} +
                        (s1_r2 ? {2'b00, cols[k][0][ch*CH_W +: CH_W]} : '0);
      end
    end
  end

  assign s2_ready = !s2_valid || s3_ready;
  assign s2_go    = s2_valid && s3_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_go && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit) begin
      s2_sb       <= col_sb;
      s2_sa       <= col_sa;
      s2_r2       <= s1_r2;
      s2_c2       <= s1_c2;
      s2_last_col <= s1_last_col;
      s2_last_row <= s1_last_row;
      s2_row      <= s1_row;
      s2_col      <= s1_col;
    end
  end

  // Results in burst order: up-left, up, left, and the current pixel itself.
  always_comb begin
    s2_code[0] = div_code(s2_r2, s2_c2);
    s2_code[1] = div_code(s2_r2, 1'b0);
    s2_code[2] = div_code(1'b0, s2_c2);
    s2_code[3] = DIV4;
    for (int ch = 0; ch < 3; ch++) begin
      s2_tot[0][ch] = (s2_c2 ? SUM_W'(s2_sa[0][ch]) : '0) + SUM_W'(s2_sa[1][ch]) +
                      SUM_W'(s2_sa[2][ch]) + SUM_W'(div_half(s2_code[0]));
      s2_tot[1][ch] = SUM_W'(s2_sa[1][ch]) + SUM_W'(s2_sa[2][ch]) +
                      SUM_W'(div_half(s2_code[1]));
      s2_tot[2][ch] = (s2_c2 ? SUM_W'(s2_sb[0][ch]) : '0) + SUM_W'(s2_sb[1][ch]) +
                      SUM_W'(s2_sb[2][ch]) + SUM_W'(div_half(s2_code[2]));
      s2_tot[3][ch] = SUM_W'(s2_sb[1][ch]) + SUM_W'(s2_sb[2][ch]) +
                      SUM_W'(div_half(s2_code[3]));
    end
  end

  assign out_load = !res_valid || res_ready;
  assign s3_emit  = s3_valid && out_load;
  assign s3_ready = !s3_valid || (out_load && !s3_more);

  always_comb begin
    s3_more = 1'b0;
    s3_next = s3_sel;
    for (int j = 3; j >= 0; j--) begin
      if (2'(j) > s3_sel && s3_mask[j]) begin
        s3_more = 1'b1;
        s3_next = 2'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      s3_tot      <= s2_tot;
      s3_code     <= s2_code;
      s3_mask     <= {s2_last_col && s2_last_row, s2_last_row, s2_last_col, 1'b1};
      s3_sel      <= 2'd0;
      s3_row_up   <= s2_row - POS_W'(1);
      s3_row      <= s2_row;
      s3_col_left <= s2_col - POS_W'(1);
      s3_col      <= s2_col;
    end else if (s3_emit && s3_more) begin
      s3_sel <= s3_next;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = PROD_W'(s3_tot[s3_sel][ch]) * PROD_W'(div_recip(s3_code[s3_sel]));
    end
    res_next.red_out       = prod[2][RECIP_SHIFT +: CH_W];
    res_next.green_out     = prod[1][RECIP_SHIFT +: CH_W];
    res_next.blue_out      = prod[0][RECIP_SHIFT +: CH_W];
    res_next.out_row       = s3_sel[1] ? s3_row : s3_row_up;
    res_next.out_col       = s3_sel[0] ? s3_col : s3_col_left;
    res_next.last_of_burst = !s3_more;
    res_next.last_of_frame = (s3_sel == SLOT_LAST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_emit) begin
      res <= res_next;
    end
  end

endmodule
